>>> rtl/sdda_pkg.sv
// Shared types and constants for the scaled DDA line rasterizer.
`timescale 1ns / 1ps

package sdda_pkg;

	localparam int DIM_BITS   = 11;
	localparam int ADDR_BITS  = 22;
	localparam int COLOR_BITS = 8;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 11'd320;
	localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 11'd200;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	// minor-axis direction, two's complement
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	// action codes on the input tuser
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	typedef struct packed {
		logic                 in_frame;
		logic [ADDR_BITS-1:0] addr;
	} pix_info_t;

endpackage

>>> rtl/scaled_dda_line_rasterizer.sv
// Top level: load sequencer, line walker and output register of the rasterizer.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tuser action, tdata endpoints and color
//  m_*      out  tvalid/tready      tuser pixel_valid, tlast last_pixel, tdata pixel
//  cfg_*    in   cfg_we             cfg_index, cfg_data (frame width, height)
//
// Steps stream at one per cycle while m_tready is high and no load is in progress.
// A load holds s_tready low while the sequencer works: a sloped load passes decode,
// the multiply step and the radix-2 slope divider; a dot or axis-aligned load only decode.
// arst_n clears the walker, the sequencer and the output valid; frame size resets
// to 320 x 200. A stalled m_tready holds the pixel and blocks further transfers.
`timescale 1ns / 1ps

module scaled_dda_line_rasterizer #(
	parameter int COORD_BITS  = 12,
	parameter int SLOPE_SCALE = 2000
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                s_tvalid,
	output logic                                s_tready,
	// action
	input  logic                                s_tuser,
	// start_x, start_y, end_x, end_y, line_color
	input  logic [((4*COORD_BITS+sdda_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,

	output logic                                m_tvalid,
	input  logic                                m_tready,
	// pixel_valid
	output logic                                m_tuser,
	output logic                                m_tlast,
	// pixel_x, pixel_y, pixel_address, inside_frame, pixel_color
	output logic [((2*COORD_BITS+sdda_pkg::ADDR_BITS+1+sdda_pkg::COLOR_BITS+7)/8)*8-1:0]
		m_tdata,

	input  logic                                cfg_we,
	input  logic [sdda_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [sdda_pkg::DIM_BITS-1:0]       cfg_data
);

	localparam int C          = COORD_BITS;
	localparam int CW         = sdda_pkg::COLOR_BITS;
	localparam int AW         = sdda_pkg::ADDR_BITS;
	localparam int DW         = sdda_pkg::DIM_BITS;
	localparam int SLOPE_BITS = $clog2(SLOPE_SCALE + 1);
	localparam int ACC_BITS   = $clog2(2 * SLOPE_SCALE);
	localparam int NUM_BITS   = SLOPE_BITS + C;
	localparam int OUT_W      = ((2*C + AW + 1 + CW + 7) / 8) * 8;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic [DW-1:0] fw_q;
	logic [DW-1:0] fh_q;

	// latched load operands
	logic signed [C-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [C-1:0]        amin_q;
	logic [C-1:0]        amaj_q;
	logic                neg_q;

	// walker state
	logic                  active_q;
	logic signed [C-1:0]   walk_x_q;
	logic signed [C-1:0]   walk_y_q;
	logic signed [C-1:0]   stop_q;
	logic [SLOPE_BITS-1:0] step_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic [1:0]            dir_q;
	logic                  xmaj_q;
	logic [CW-1:0]         color_q;

	// output register
	logic                out_valid_q;
	logic                out_pv_q;
	logic                out_last_q;
	logic signed [C-1:0] out_x_q;
	logic signed [C-1:0] out_y_q;
	logic [AW-1:0]       out_addr_q;
	logic                out_inside_q;
	logic [CW-1:0]       out_color_q;

	logic s_xfer;

	// load decode
	logic signed [C:0] dx, dy;
	logic [C-1:0]      adx, ady;
	logic              xmaj, swap, sloped, neg;

	// walk
	logic signed [C-1:0]   major;
	logic                  last;
	logic [ACC_BITS-1:0]   acc_sum;
	logic                  minor_move;
	logic signed [C-1:0]   dir_ext;
	sdda_pkg::pix_info_t   pix;

	// divider
	logic                  div_start;
	logic                  div_done;
	logic [SLOPE_BITS-1:0] div_quo;
	logic [NUM_BITS-1:0]   numer;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign s_xfer   = s_tvalid && s_tready;

	always_comb begin
		dx  = (C+1)'(x1_q) - (C+1)'(x0_q);
		dy  = (C+1)'(y1_q) - (C+1)'(y0_q);
		adx = dx[C] ? C'(-dx) : C'(dx);
		ady = dy[C] ? C'(-dy) : C'(dy);
		// a dot falls on the x-major side of this compare
		xmaj   = adx >= ady;
		swap   = xmaj ? (x0_q > x1_q) : (y0_q > y1_q);
		sloped = (dx != '0) && (dy != '0);
		neg    = (xmaj ? dy[C] : dx[C]) ^ swap;
	end

	always_comb begin
		major      = xmaj_q ? walk_x_q : walk_y_q;
		last       = major >= stop_q;
		acc_sum    = acc_q + ACC_BITS'(step_q);
		minor_move = acc_sum >= ACC_BITS'(SLOPE_SCALE);
		dir_ext    = {{(C-2){dir_q[1]}}, dir_q};
	end

	assign div_start = (state_q == ST_MUL);
	assign numer     = NUM_BITS'(SLOPE_SCALE) * NUM_BITS'(amin_q);

	sdda_div #(
		.NUM_BITS (NUM_BITS),
		.DEN_BITS (C),
		.QUO_BITS (SLOPE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (numer),
		.denom    (amaj_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	sdda_pix #(
		.COORD_BITS (C)
	) u_pix (
		.px           (walk_x_q),
		.py           (walk_y_q),
		.frame_width  (fw_q),
		.frame_height (fh_q),
		.info         (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= sdda_pkg::FRAME_WIDTH_RST;
			fh_q <= sdda_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdda_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_data;
				sdda_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser == sdda_pkg::ACT_LOAD) begin
			x0_q <= s_tdata[C-1:0];
			y0_q <= s_tdata[2*C-1:C];
			x1_q <= s_tdata[3*C-1:2*C];
			y1_q <= s_tdata[4*C-1:3*C];
		end
		if (state_q == ST_PREP) begin
			amin_q <= xmaj ? ady : adx;
			amaj_q <= xmaj ? adx : ady;
			neg_q  <= neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
			walk_x_q <= '0;
			walk_y_q <= '0;
			stop_q   <= '0;
			step_q   <= '0;
			acc_q    <= '0;
			dir_q    <= sdda_pkg::DIR_NONE;
			xmaj_q   <= 1'b0;
			color_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer && s_tuser == sdda_pkg::ACT_LOAD) begin
						color_q <= s_tdata[4*C+CW-1:4*C];
						state_q <= ST_PREP;
					end else if (s_xfer && active_q) begin
						if (last) begin
							active_q <= 1'b0;
						end else begin
							acc_q <= minor_move ? acc_sum - ACC_BITS'(SLOPE_SCALE) : acc_sum;
							if (xmaj_q) begin
								walk_x_q <= walk_x_q + C'(1);
								if (minor_move) begin
									walk_y_q <= walk_y_q + dir_ext;
								end
							end else begin
								walk_y_q <= walk_y_q + C'(1);
								if (minor_move) begin
									walk_x_q <= walk_x_q + dir_ext;
								end
							end
						end
					end
				end
				ST_PREP: begin
					active_q <= 1'b1;
					step_q   <= '0;
					acc_q    <= '0;
					dir_q    <= sdda_pkg::DIR_NONE;
					xmaj_q   <= xmaj;
					walk_x_q <= swap ? x1_q : x0_q;
					walk_y_q <= swap ? y1_q : y0_q;
					stop_q   <= xmaj ? (swap ? x0_q : x1_q) : (swap ? y0_q : y1_q);
					state_q  <= sloped ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						step_q  <= div_quo;
						dir_q   <= (div_quo == '0) ? sdda_pkg::DIR_NONE :
						           (neg_q ? sdda_pkg::DIR_NEG : sdda_pkg::DIR_POS);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_xfer && s_tuser == sdda_pkg::ACT_STEP) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser == sdda_pkg::ACT_STEP) begin
			// with no line loaded, emit an all-zero result
			out_pv_q     <= active_q;
			out_x_q      <= active_q ? walk_x_q : '0;
			out_y_q      <= active_q ? walk_y_q : '0;
			out_addr_q   <= active_q ? pix.addr : '0;
			out_inside_q <= active_q && pix.in_frame;
			out_color_q  <= active_q ? color_q : '0;
			out_last_q   <= active_q && last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_pv_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_W'({out_color_q, out_inside_q, out_addr_q, out_y_q, out_x_q});

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= SLOPE_BITS'(SLOPE_SCALE))
		else $error("slope step exceeds scale");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < ACC_BITS'(SLOPE_SCALE))
		else $error("accumulator not reduced below scale");

	a_load_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(s_xfer && s_tuser == sdda_pkg::ACT_LOAD) |=> state_q == ST_PREP)
		else $error("load did not enter decode");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide phase");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q == sdda_pkg::DIR_NONE || dir_q == sdda_pkg::DIR_POS ||
		dir_q == sdda_pkg::DIR_NEG)
		else $error("bad minor direction");

endmodule

>>> rtl/sdda_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, for the slope.
`timescale 1ns / 1ps

module sdda_div #(
	parameter int NUM_BITS = 23,
	parameter int DEN_BITS = 12,
	parameter int QUO_BITS = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] numer,
	input  logic [DEN_BITS-1:0] denom,
	output logic                done,
	output logic [QUO_BITS-1:0] quotient
);

	localparam int CNT_BITS = (QUO_BITS > 1) ? $clog2(QUO_BITS) : 1;

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] den_q;
	logic [QUO_BITS-1:0] quo_q;
	logic                fits;

	assign fits = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QUO_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			// quotient never exceeds QUO_BITS, so start at the top quotient bit
			den_q <= NUM_BITS'(denom) << (QUO_BITS - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
			den_q <= den_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/sdda_pix.sv
// Frame clipping and linear frame address for the current pixel.
`timescale 1ns / 1ps

module sdda_pix #(
	parameter int COORD_BITS = 12
) (
	input  logic signed [COORD_BITS-1:0]      px,
	input  logic signed [COORD_BITS-1:0]      py,
	input  logic [sdda_pkg::DIM_BITS-1:0]     frame_width,
	input  logic [sdda_pkg::DIM_BITS-1:0]     frame_height,
	output sdda_pkg::pix_info_t               info
);

	localparam int DW = sdda_pkg::DIM_BITS;
	localparam int AW = sdda_pkg::ADDR_BITS;
	localparam int XW = (COORD_BITS > DW) ? COORD_BITS : DW;

	logic [XW-1:0] px_ext;
	logic [XW-1:0] py_ext;
	logic          in_frame;

	always_comb begin
		px_ext = XW'($unsigned(px));
		py_ext = XW'($unsigned(py));
		in_frame = !px[COORD_BITS-1] && (px_ext < XW'(frame_width)) &&
		           !py[COORD_BITS-1] && (py_ext < XW'(frame_height));
		info.in_frame = in_frame;
		// inside the frame both coordinates fit the dimension width
		info.addr = in_frame ?
			(AW'(py_ext[DW-1:0]) * AW'(frame_width) + AW'(px_ext[DW-1:0])) : '0;
	end

endmodule
